// File: design/aes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aes_pkg;

  localparam int BLK_W   = 128;
  localparam int NROUNDS = 14;
  localparam int NKROWS  = NROUNDS + 1;
  localparam int NKWORDS = 60;
  localparam int QDEPTH  = 2;

  // configuration register indexes
  localparam logic [2:0] REG_KEY0    = 3'd0;
  localparam logic [2:0] REG_KEY1    = 3'd1;
  localparam logic [2:0] REG_KEY2    = 3'd2;
  localparam logic [2:0] REG_KEY3    = 3'd3;
  localparam logic [2:0] REG_IV_HIGH = 3'd4;
  localparam logic [2:0] REG_IV_LOW  = 3'd5;
  localparam logic [2:0] REG_MODE    = 3'd6;

  localparam logic [2:0] MODE_ECB_ENC = 3'd0;
  localparam logic [2:0] MODE_ECB_DEC = 3'd1;
  localparam logic [2:0] MODE_CBC_ENC = 3'd2;
  localparam logic [2:0] MODE_CBC_DEC = 3'd3;
  localparam logic [2:0] MODE_CTR     = 3'd4;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] GF_POLY    = 8'h1b;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_ECB_ENC = 3'd1,
    OP_ECB_DEC = 3'd2,
    OP_CBC_ENC = 3'd3,
    OP_CBC_DEC = 3'd4,
    OP_CTR     = 3'd5
  } op_t;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  typedef struct packed {
    op_t          op;
    logic [127:0] blk;
    logic         first;
  } job_t;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] b);
    xt = {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
  endfunction

  // multiply by a constant below 16
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [3:0] c);
    logic [7:0] a2, a4, a8;
    a2 = xt(a);
    a4 = xt(a2);
    a8 = xt(a4);
    gf_mul = (c[0] ? a : 8'h00) ^ (c[1] ? a2 : 8'h00) ^
             (c[2] ? a4 : 8'h00) ^ (c[3] ? a8 : 8'h00);
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    t = '0;
    for (int i = 0; i < 16; i++) begin
      t[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : FWD_SBOX[s[127-8*i -: 8]];
    end
    sub_bytes = t;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          t[127-8*(((c+r)%4)*4+r) -: 8] = s[127-8*(c*4+r) -: 8];
        end else begin
          t[127-8*(c*4+r) -: 8] = s[127-8*(((c+r)%4)*4+r) -: 8];
        end
      end
    end
    shift_rows = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [3:0]   m [4];
    logic [7:0]   o;
    if (inv) begin
      m[0] = 4'd14; m[1] = 4'd11; m[2] = 4'd13; m[3] = 4'd9;
    end else begin
      m[0] = 4'd2;  m[1] = 4'd3;  m[2] = 4'd1;  m[3] = 4'd1;
    end
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o = 8'h00;
        for (int k = 0; k < 4; k++) begin
          o = o ^ gf_mul(s[127-8*(c*4+k) -: 8], m[(k-r+4)%4]);
        end
        t[127-8*(c*4+r) -: 8] = o;
      end
    end
    mix_columns = t;
  endfunction

endpackage

`default_nettype wire

// File: design/aes256_block_cipher_modes.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   handshake              payload
// input     push / full            din  (in_item_t)
// result    empty / pop            dout (out_item_t)
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an item steps through the round engine: issue, operand load, key add, 14 rounds
// through one shared round unit, and the result write; the front queue holds two items
// after reset, and after every key write, the key schedule expands all 60 words
// before the engine starts an item; items may be pushed meanwhile
// a result waiting in the output register holds the engine in its last step

module aes256_block_cipher_modes
  import aes_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    din,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        dout,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [3:0][63:0]            key;
  logic [63:0]                 iv_high, iv_low;
  logic [2:0]                  mode;
  logic                        key_wr, key_busy;
  logic                        job_valid, job_pop;
  job_t                        job;
  logic                        ram_we;
  logic [$clog2(NKROWS)-1:0]   ram_waddr, ram_raddr;
  logic [127:0]                ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;
  assign key_wr = cfg_valid && (cfg_index == REG_KEY0 || cfg_index == REG_KEY1 ||
                                cfg_index == REG_KEY2 || cfg_index == REG_KEY3);

  always_ff @(posedge clk) begin
    if (rst) begin
      key     <= '0;
      iv_high <= '0;
      iv_low  <= '0;
      mode    <= MODE_ECB_ENC;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY0:    key[0]  <= cfg_data;
        REG_KEY1:    key[1]  <= cfg_data;
        REG_KEY2:    key[2]  <= cfg_data;
        REG_KEY3:    key[3]  <= cfg_data;
        REG_IV_HIGH: iv_high <= cfg_data;
        REG_IV_LOW:  iv_low  <= cfg_data;
        REG_MODE:    mode    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  aes_keyexp u_keyexp (
    .clk     (clk),
    .rst     (rst),
    .restart (key_wr),
    .key     (key),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .busy    (key_busy)
  );

  aes_ram #(.WIDTH(128), .DEPTH(NKROWS)) u_rk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  aes_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .din       (din),
    .mode      (mode),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job)
  );

  aes_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .key_busy  (key_busy),
    .iv_high   (iv_high),
    .iv_low    (iv_low),
    .raddr     (ram_raddr),
    .rkey      (ram_rdata),
    .empty     (empty),
    .pop       (pop),
    .dout      (dout)
  );

endmodule

`default_nettype wire

// File: design/aes_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module aes_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/aes_keyexp.sv
`timescale 1ns / 1ps
`default_nettype none

module aes_keyexp
  import aes_pkg::*;
(
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           restart,
  input  wire logic [3:0][63:0]               key,
  output logic                                we,
  output logic [$clog2(NKROWS)-1:0]           waddr,
  output logic [127:0]                        wdata,
  output logic                                busy
);

  logic [$clog2(NKWORDS)-1:0] cnt;
  logic [7:0]                 rc;
  logic [31:0]                win [8];   // win[0] is word i-8, win[7] word i-1
  logic [31:0]                w, t;

  always_comb begin
    t = win[7];
    if (cnt[2:0] == 3'd0) begin
      t = sub_word({win[7][23:0], win[7][31:24]}) ^ {rc, 24'h0};
    end else if (cnt[2:0] == 3'd4) begin
      t = sub_word(win[7]);
    end
    if (cnt < ($clog2(NKWORDS))'(8)) begin
      w = cnt[0] ? key[cnt[2:1]][31:0] : key[cnt[2:1]][63:32];
    end else begin
      w = win[0] ^ t;
    end
  end

  assign we    = busy && (cnt[1:0] == 2'd3);
  assign waddr = cnt[$clog2(NKWORDS)-1:2];
  assign wdata = {win[5], win[6], win[7], w};

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      busy <= 1'b1;
      cnt  <= '0;
      rc   <= RCON_FIRST;
    end else if (busy) begin
      for (int i = 0; i < 7; i++) begin
        win[i] <= win[i+1];
      end
      win[7] <= w;
      if (cnt >= ($clog2(NKWORDS))'(8) && cnt[2:0] == 3'd0) begin
        rc <= {rc[6:0], 1'b0};
      end
      if (cnt == ($clog2(NKWORDS))'(NKWORDS - 1)) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/aes_front.sv
`timescale 1ns / 1ps
`default_nettype none

module aes_front
  import aes_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t din,
  input  wire logic [2:0] mode,
  output logic          job_valid,
  input  wire logic     job_pop,
  output job_t          job
);

  job_t                        q [QDEPTH];
  logic [$clog2(QDEPTH)-1:0]   wptr, rptr;
  logic [$clog2(QDEPTH+1)-1:0] count;
  logic                        do_push, do_pop;
  op_t                         op;

  always_comb begin
    unique case (mode)
      MODE_ECB_ENC: op = OP_ECB_ENC;
      MODE_ECB_DEC: op = OP_ECB_DEC;
      MODE_CBC_ENC: op = OP_CBC_ENC;
      MODE_CBC_DEC: op = OP_CBC_DEC;
      MODE_CTR:     op = OP_CTR;
      default:      op = OP_NONE;
    endcase
  end

  assign full      = (count == ($clog2(QDEPTH+1))'(QDEPTH));
  assign job_valid = (count != '0);
  assign job       = q[rptr];
  assign do_push   = push && !full;
  assign do_pop    = job_pop && job_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wptr] <= '{op: op, blk: {din.block_high, din.block_low}, first: din.first_block};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/aes_back.sv
`timescale 1ns / 1ps
`default_nettype none

module aes_back
  import aes_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       job_valid,
  input  wire job_t                       job,
  output logic                            job_pop,
  input  wire logic                       key_busy,
  input  wire logic [63:0]                iv_high,
  input  wire logic [63:0]                iv_low,
  output logic [$clog2(NKROWS)-1:0]       raddr,
  input  wire logic [127:0]               rkey,
  output logic                            empty,
  input  wire logic                       pop,
  output out_item_t                       dout
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_RUN  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  localparam int RW = $clog2(NROUNDS + 1);

  state_t         state;
  job_t           cur;
  logic [127:0]   st, st_next, chain, fin;
  logic [31:0]    ctr;
  logic [RW-1:0]  rnd;
  logic           dec;
  logic [127:0]   enc_x, dec_x;
  logic           slot_free;

  assign dec       = (cur.op == OP_ECB_DEC) || (cur.op == OP_CBC_DEC);
  assign job_pop   = (state == S_IDLE) && job_valid && !key_busy;
  assign slot_free = empty || pop;

  // key row for the step after this one
  always_comb begin
    raddr = '0;
    if (state == S_LOAD) begin
      raddr = dec ? ($clog2(NKROWS))'(NROUNDS) : '0;
    end else if (state == S_RUN && rnd != RW'(NROUNDS)) begin
      raddr = dec ? ($clog2(NKROWS))'(NROUNDS - 1) - ($clog2(NKROWS))'(rnd)
                  : ($clog2(NKROWS))'(rnd) + 1'b1;
    end
  end

  always_comb begin
    enc_x = shift_rows(sub_bytes(st, 1'b0), 1'b0);
    if (rnd != RW'(NROUNDS)) enc_x = mix_columns(enc_x, 1'b0);
    enc_x = enc_x ^ rkey;
    dec_x = sub_bytes(shift_rows(st, 1'b1), 1'b1) ^ rkey;
    if (rnd != RW'(NROUNDS)) dec_x = mix_columns(dec_x, 1'b1);
    if (rnd == '0) begin
      st_next = st ^ rkey;
    end else begin
      st_next = dec ? dec_x : enc_x;
    end
  end

  always_comb begin
    unique case (cur.op)
      OP_CTR:     fin = st ^ cur.blk;
      OP_CBC_DEC: fin = st ^ chain;
      default:    fin = st;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      empty <= 1'b1;
      chain <= '0;
      ctr   <= '0;
      rnd   <= '0;
    end else begin
      // in the last step a pop frees the slot and the new result refills it
      if (pop && !empty && state != S_DONE) empty <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (job_pop) begin
            cur   <= job;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          rnd   <= '0;
          state <= S_RUN;
          unique case (cur.op)
            OP_CBC_ENC: begin
              st <= cur.blk ^ (cur.first ? {iv_high, iv_low} : chain);
              if (cur.first) chain <= {iv_high, iv_low};
            end
            OP_CBC_DEC: begin
              st <= cur.blk;
              if (cur.first) chain <= {iv_high, iv_low};
            end
            OP_CTR: begin
              st <= {iv_high, iv_low[63:32], cur.first ? iv_low[31:0] : ctr};
              if (cur.first) ctr <= iv_low[31:0];
            end
            OP_NONE: begin
              st    <= '0;
              state <= S_DONE;
            end
            default: st <= cur.blk;
          endcase
        end
        S_RUN: begin
          st  <= st_next;
          rnd <= rnd + 1'b1;
          if (rnd == RW'(NROUNDS)) state <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            dout  <= '{result_high: fin[127:64], result_low: fin[63:0]};
            empty <= 1'b0;
            state <= S_IDLE;
            unique case (cur.op)
              OP_CBC_ENC: chain <= fin;
              OP_CBC_DEC: chain <= cur.blk;
              OP_CTR:     ctr   <= ctr + 1'b1;
              default: ;
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
